/* sv/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, character codes and constants of the sixel stream decoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned MAX_SIDE_DEF  = 4096;
  localparam int unsigned PAL_DEPTH_DEF = 256;

  localparam logic [17:0] SAT18     = 18'h3FFFF;
  localparam logic [16:0] PARAM_CAP = 17'd100000;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] SIXEL_LO  = 8'h3F;
  localparam logic [7:0] SIXEL_HI  = 8'h7E;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [3:0] HLS_LAST_STEP = 4'd3;
  localparam logic [1:0] HLS_LAST_CH   = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COLOR,
    MODE_REPEAT,
    MODE_RASTER
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HLS,
    ST_PWR,
    ST_RD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic hls_run;
    logic pwr;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic define;
    logic hls;
    logic hls_done;
    logic out_busy;
  } sts_t;

  // percent (0..100) to 8 bits, truncated: p*255/100 via reciprocal
  function automatic logic [7:0] pct255(input logic [6:0] p);
    logic [14:0] s;
    logic [27:0] m;
    s = 15'(p) * 15'd255;
    m = 28'(s) * 28'd5243;
    return m[26:19];
  endfunction

endpackage

/* sv/ssd_ctrl.sv */
// ----------------------------------------------------------------------------
// ssd_ctrl
// Sequencer of the sixel stream decoder: one byte per pass.
// ----------------------------------------------------------------------------
module ssd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssd_pkg::sts_t sts_i,
  output ssd_pkg::cmd_t cmd_o
);

  ssd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ssd_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ssd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ssd_pkg::ST_EXEC;
        end
      end
      ssd_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ssd_pkg::ST_RD;
      end
      ssd_pkg::ST_RD: begin
        if (sts_i.define && sts_i.hls) begin
          state_d = ssd_pkg::ST_HLS;
        end else if (sts_i.define) begin
          state_d = ssd_pkg::ST_PWR;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ssd_pkg::ST_OUT;
        end
      end
      ssd_pkg::ST_HLS: begin
        cmd_o.hls_run = 1'b1;
        if (sts_i.hls_done) state_d = ssd_pkg::ST_PWR;
      end
      ssd_pkg::ST_PWR: begin
        cmd_o.pwr = 1'b1;
        state_d   = ssd_pkg::ST_RD;
      end
      ssd_pkg::ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ssd_pkg::ST_IDLE;
        end
      end
      default: state_d = ssd_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/ssd_dp.sv */
// ----------------------------------------------------------------------------
// ssd_dp
// Datapath of the sixel stream decoder: parser, cursor, palette, HLS unit.
// ----------------------------------------------------------------------------
module ssd_dp #(
  parameter int unsigned MAX_SIDE      = ssd_pkg::MAX_SIDE_DEF,
  parameter int unsigned PALETTE_DEPTH = ssd_pkg::PAL_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssd_pkg::cmd_t cmd_i,
  output ssd_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [12:0]   cfg_data_i,
  input  logic [7:0]    stream_byte_i,
  input  logic          start_image_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          draw_valid_o,
  output logic [17:0]   draw_x_o,
  output logic [17:0]   draw_row_o,
  output logic [16:0]   run_length_o,
  output logic [5:0]    row_mask_o,
  output logic [23:0]   color_rgb_o,
  output logic [17:0]   extent_width_o,
  output logic [17:0]   extent_height_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam logic [16:0] SIDE_MAX = 17'(MAX_SIDE);
  localparam logic [16:0] REG_MAX  = 17'(PALETTE_DEPTH - 1);

  // configuration
  logic [16:0] clip_w_q, clip_h_q, cfg_clip;
  assign cfg_clip = (17'(cfg_data_i) < SIDE_MAX) ? 17'(cfg_data_i) : SIDE_MAX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_w_q <= SIDE_MAX;
      clip_h_q <= SIDE_MAX;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ssd_pkg::REG_WIDTH) clip_w_q <= cfg_clip;
      else                                   clip_h_q <= cfg_clip;
    end
  end

  // state
  logic [7:0]     byte_q;
  logic           start_q;
  logic [17:0]    cursor_q, band_q, reach_col_q, reach_row_q;
  logic [16:0]    rw_q, rh_q;
  logic [AW-1:0]  sel_q, pend_q;
  ssd_pkg::mode_e mode_q;
  logic [16:0]    dval_q;
  logic           dseen_q;
  logic [2:0]     slot_q;
  logic [16:0]    pv_q [4];
  logic [3:0]     pp_q;
  logic           define_q, hls_q;

  // start-of-image view
  logic [17:0]    s_cursor, s_band, s_reach_col, s_reach_row;
  logic [16:0]    s_rw, s_rh;
  logic [AW-1:0]  s_pend;
  ssd_pkg::mode_e s_mode;
  logic [16:0]    s_dval;
  logic           s_dseen;
  logic [2:0]     s_slot;
  logic [16:0]    s_pv [4];
  logic [3:0]     s_pp;

  always_comb begin
    s_cursor    = start_q ? '0 : cursor_q;
    s_band      = start_q ? '0 : band_q;
    s_reach_col = start_q ? '0 : reach_col_q;
    s_reach_row = start_q ? '0 : reach_row_q;
    s_rw        = start_q ? '0 : rw_q;
    s_rh        = start_q ? '0 : rh_q;
    s_pend      = start_q ? '0 : pend_q;
    s_mode      = start_q ? ssd_pkg::MODE_IDLE : mode_q;
    s_dval      = start_q ? '0 : dval_q;
    s_dseen     = start_q ? 1'b0 : dseen_q;
    s_slot      = start_q ? '0 : slot_q;
    s_pp        = start_q ? '0 : pp_q;
    for (int i = 0; i < 4; i++) s_pv[i] = start_q ? '0 : pv_q[i];
  end

  // byte classes
  logic is_digit, is_semi, is_sixel;
  logic [20:0] acc;
  assign is_digit = (byte_q >= ssd_pkg::CH_ZERO) && (byte_q <= ssd_pkg::CH_NINE);
  assign is_semi  = (byte_q == ssd_pkg::CH_SEMI);
  assign is_sixel = (byte_q >= ssd_pkg::SIXEL_LO) && (byte_q <= ssd_pkg::SIXEL_HI);
  assign acc      = 21'(s_dval) * 21'd10 + 21'(byte_q[3:0]);

  // parser next state
  logic [17:0]    n_cursor, n_band;
  logic [16:0]    n_rw, n_rh, n_dval, count;
  logic [AW-1:0]  n_sel, n_pend;
  ssd_pkg::mode_e n_mode;
  logic           n_dseen, consumed, semi_acc, close_cmd, draw_en, n_define, n_hls;
  logic [2:0]     n_slot;
  logic [16:0]    n_pv [4];
  logic [3:0]     n_pp;
  logic [5:0]     bits;
  logic [18:0]    band_inc;

  assign band_inc = 19'(s_band) + 19'd6;

  always_comb begin
    n_cursor  = s_cursor;
    n_band    = s_band;
    n_rw      = s_rw;
    n_rh      = s_rh;
    n_sel     = start_q ? '0 : sel_q;
    n_pend    = s_pend;
    n_mode    = s_mode;
    n_dval    = s_dval;
    n_dseen   = s_dseen;
    n_slot    = s_slot;
    n_pv      = s_pv;
    n_pp      = s_pp;
    consumed  = 1'b0;
    semi_acc  = 1'b0;
    close_cmd = 1'b0;
    draw_en   = 1'b0;
    n_define  = 1'b0;
    n_hls     = 1'b0;
    bits      = byte_q[5:0] - ssd_pkg::SIXEL_LO[5:0];
    count     = 17'd1;

    if (s_mode != ssd_pkg::MODE_IDLE) begin
      if (is_digit) begin
        n_dval   = (acc > 21'(ssd_pkg::PARAM_CAP)) ? ssd_pkg::PARAM_CAP : acc[16:0];
        n_dseen  = 1'b1;
        consumed = 1'b1;
      end else if (is_semi && (((s_mode == ssd_pkg::MODE_COLOR) && (s_slot < 3'd4)) ||
                               ((s_mode == ssd_pkg::MODE_RASTER) && (s_slot < 3'd3)))) begin
        semi_acc = 1'b1;
        consumed = 1'b1;
      end else if ((s_mode == ssd_pkg::MODE_REPEAT) && is_sixel) begin
        count    = (s_dseen && (s_dval != '0)) ? s_dval : 17'd1;
        n_mode   = ssd_pkg::MODE_IDLE;
        n_dval   = '0;
        n_dseen  = 1'b0;
        draw_en  = 1'b1;
        consumed = 1'b1;
      end else begin
        close_cmd = 1'b1;
      end
    end

    // close the open parameter
    if (semi_acc || (close_cmd && ((s_mode == ssd_pkg::MODE_COLOR) ||
                                   (s_mode == ssd_pkg::MODE_RASTER)))) begin
      if (s_mode == ssd_pkg::MODE_COLOR) begin
        if (s_slot == 3'd0) begin
          n_pend = (s_dval > REG_MAX) ? REG_MAX[AW-1:0] : s_dval[AW-1:0];
        end else if (s_slot <= 3'd4) begin
          n_pv[s_slot[1:0] - 2'd1] = s_dval;
          n_pp[s_slot[1:0] - 2'd1] = s_dseen;
        end
      end else begin
        if ((s_slot == 3'd2) && s_dseen) n_rw = s_dval;
        if ((s_slot == 3'd3) && s_dseen) n_rh = s_dval;
      end
    end

    if (semi_acc) begin
      n_slot  = s_slot + 3'd1;
      n_dval  = '0;
      n_dseen = 1'b0;
    end

    if (close_cmd) begin
      if (s_mode == ssd_pkg::MODE_COLOR) begin
        n_sel    = n_pend;
        n_define = (s_slot == 3'd4) && n_pp[0];
        n_hls    = (n_pv[0] == 17'd1);
      end
      n_mode  = ssd_pkg::MODE_IDLE;
      n_slot  = '0;
      n_dval  = '0;
      n_dseen = 1'b0;
    end

    if (!consumed) begin
      unique case (byte_q)
        ssd_pkg::CH_QUOTE: begin
          n_mode = ssd_pkg::MODE_RASTER; n_slot = '0; n_dval = '0; n_dseen = 1'b0;
        end
        ssd_pkg::CH_HASH: begin
          n_mode = ssd_pkg::MODE_COLOR; n_slot = '0; n_dval = '0; n_dseen = 1'b0;
        end
        ssd_pkg::CH_BANG: begin
          n_mode = ssd_pkg::MODE_REPEAT; n_slot = '0; n_dval = '0; n_dseen = 1'b0;
        end
        ssd_pkg::CH_DOLLAR: n_cursor = '0;
        ssd_pkg::CH_MINUS: begin
          n_cursor = '0;
          n_band   = (band_inc > 19'(ssd_pkg::SAT18)) ? ssd_pkg::SAT18 : band_inc[17:0];
        end
        default: draw_en = is_sixel;
      endcase
    end
  end

  // run write
  logic [16:0] diff, run;
  logic [5:0]  rows, mask;
  logic [2:0]  hb;
  logic [18:0] cur_sum, row_sum;
  logic [17:0] dr_cursor, dr_reach_col, dr_reach_row, row_top;
  logic        dr_valid;

  always_comb begin
    diff = clip_w_q - s_cursor[16:0];
    if (s_cursor >= 18'(clip_w_q)) run = '0;
    else                           run = (count < diff) ? count : diff;
    hb = '0;
    for (int b = 0; b < 6; b++) begin
      rows[b] = (19'(s_band) + 19'(b)) < 19'(clip_h_q);
      if (bits[b]) hb = 3'(b + 1);
    end
    mask         = bits & rows;
    dr_valid     = (run != '0) && (mask != '0);
    cur_sum      = 19'(s_cursor) + 19'(count);
    dr_cursor    = (cur_sum > 19'(ssd_pkg::SAT18)) ? ssd_pkg::SAT18 : cur_sum[17:0];
    dr_reach_col = (dr_cursor > s_reach_col) ? dr_cursor : s_reach_col;
    row_sum      = 19'(s_band) + 19'(hb);
    row_top      = (row_sum > 19'(ssd_pkg::SAT18)) ? ssd_pkg::SAT18 : row_sum[17:0];
    dr_reach_row = ((bits != '0) && (row_top > s_reach_row)) ? row_top : s_reach_row;
  end

  // color from define parameters
  logic [6:0] pa, pb, pc;
  logic [8:0] hue_c;
  logic [9:0] hue_s;
  assign pa    = (n_pv[1] > 17'd100) ? 7'd100 : n_pv[1][6:0];
  assign pb    = (n_pv[2] > 17'd100) ? 7'd100 : n_pv[2][6:0];
  assign pc    = (n_pv[3] > 17'd100) ? 7'd100 : n_pv[3][6:0];
  assign hue_c = (n_pv[1] > 17'd360) ? 9'd360 : n_pv[1][8:0];
  assign hue_s = 10'(hue_c) + 10'd240;

  // HLS unit
  logic [8:0]         h_q;
  logic [6:0]         lig_q, sat_q;
  logic [1:0]         ch_q;
  logic [3:0]         step_q;
  logic signed [5:0]  t_q;
  logic [12:0]        prod1_q;
  logic [18:0]        num_q;
  logic [22:0]        rem_q;
  logic [36:0]        qprod;
  logic [7:0]         quo;
  logic [23:0]        rgb_q;
  logic [9:0]         kk;
  logic [8:0]         k, off;
  logic signed [10:0] t1, t2, tm;
  logic [6:0]         mm;
  logic signed [20:0] num_s;

  always_comb begin
    unique case (ch_q)
      2'd0:    off = 9'd0;
      2'd1:    off = 9'd240;
      default: off = 9'd120;
    endcase
    kk = 10'(h_q) + 10'(off);
    k  = (kk >= 10'd360) ? 9'(kk - 10'd360) : kk[8:0];
    t1 = $signed({2'b00, k}) - 11'sd90;
    t2 = 11'sd270 - $signed({2'b00, k});
    tm = (t2 < t1) ? t2 : t1;
    if (tm > 11'sd30)  tm = 11'sd30;
    if (tm < -11'sd30) tm = -11'sd30;
    mm = (lig_q <= (7'd100 - lig_q)) ? lig_q : (7'd100 - lig_q);
    num_s = $signed(21'(20'(lig_q) * 20'd3000)) -
            21'($signed({1'b0, prod1_q}) * t_q);
    // divide by 20000: drop 5 bits, then reciprocal of 625
    qprod = 37'(rem_q[22:5]) * 37'd429497;
    quo   = qprod[35:28];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      h_q    <= (hue_s >= 10'd360) ? 9'(hue_s - 10'd360) : hue_s[8:0];
      lig_q  <= pb;
      sat_q  <= pc;
      ch_q   <= '0;
      step_q <= '0;
      rgb_q  <= {ssd_pkg::pct255(pa), ssd_pkg::pct255(pb), ssd_pkg::pct255(pc)};
    end else if (cmd_i.hls_run) begin
      unique case (step_q)
        4'd0: begin
          t_q     <= 6'(tm);
          prod1_q <= 13'(sat_q) * 13'(mm);
        end
        4'd1:    num_q <= num_s[18:0];
        4'd2:    rem_q <= 23'(num_q) * 23'd17 + 23'd10000;
        default: ;
      endcase
      if (step_q == ssd_pkg::HLS_LAST_STEP) begin
        unique case (ch_q)
          2'd0:    rgb_q[23:16] <= quo;
          2'd1:    rgb_q[15:8]  <= quo;
          default: rgb_q[7:0]   <= quo;
        endcase
        ch_q   <= ch_q + 2'd1;
        step_q <= '0;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  // palette
  logic [23:0]              pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] def_q;
  logic [23:0]              rd_q;
  logic                     rd_def_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pwr) pal_mem[sel_q] <= rgb_q;
    if (cmd_i.rd)  rd_q <= pal_mem[sel_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q    <= '0;
      rd_def_q <= 1'b0;
    end else begin
      if (cmd_i.exec && start_q) def_q <= '0;
      else if (cmd_i.pwr)        def_q[sel_q] <= 1'b1;
      if (cmd_i.rd) rd_def_q <= def_q[sel_q];
    end
  end

  // parser and cursor registers
  logic        drv_q;
  logic [17:0] drx_q, drrow_q;
  logic [16:0] drrun_q;
  logic [5:0]  drmask_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q  <= stream_byte_i;
      start_q <= start_image_i;
    end
    if (cmd_i.exec) begin
      drv_q    <= draw_en && dr_valid;
      drx_q    <= (draw_en && dr_valid) ? s_cursor : '0;
      drrow_q  <= (draw_en && dr_valid) ? s_band : '0;
      drrun_q  <= (draw_en && dr_valid) ? run : '0;
      drmask_q <= (draw_en && dr_valid) ? mask : '0;
      pv_q     <= n_pv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      band_q      <= '0;
      reach_col_q <= '0;
      reach_row_q <= '0;
      rw_q        <= '0;
      rh_q        <= '0;
      sel_q       <= '0;
      pend_q      <= '0;
      mode_q      <= ssd_pkg::MODE_IDLE;
      dval_q      <= '0;
      dseen_q     <= 1'b0;
      slot_q      <= '0;
      pp_q        <= '0;
      define_q    <= 1'b0;
      hls_q       <= 1'b0;
    end else if (cmd_i.exec) begin
      cursor_q    <= draw_en ? dr_cursor : n_cursor;
      band_q      <= n_band;
      reach_col_q <= draw_en ? dr_reach_col : s_reach_col;
      reach_row_q <= draw_en ? dr_reach_row : s_reach_row;
      rw_q        <= n_rw;
      rh_q        <= n_rh;
      sel_q       <= n_sel;
      pend_q      <= n_pend;
      mode_q      <= n_mode;
      dval_q      <= n_dval;
      dseen_q     <= n_dseen;
      slot_q      <= n_slot;
      pp_q        <= n_pp;
      define_q    <= n_define;
      hls_q       <= n_hls;
    end else if (cmd_i.pwr) begin
      define_q <= 1'b0;
    end
  end

  // output register
  logic        ov_q;
  logic        odv_q;
  logic [17:0] ox_q, orow_q, oew_q, oeh_q;
  logic [16:0] orun_q;
  logic [5:0]  omask_q;
  logic [23:0] ocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             ov_q <= 1'b0;
    else if (cmd_i.out_load) ov_q <= 1'b1;
    else if (out_ready_i)    ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      odv_q   <= drv_q;
      ox_q    <= drx_q;
      orow_q  <= drrow_q;
      orun_q  <= drrun_q;
      omask_q <= drmask_q;
      ocol_q  <= (drv_q && rd_def_q) ? rd_q : '0;
      oew_q   <= (reach_col_q > 18'(rw_q)) ? reach_col_q : 18'(rw_q);
      oeh_q   <= (reach_row_q > 18'(rh_q)) ? reach_row_q : 18'(rh_q);
    end
  end

  assign sts_o.define   = define_q;
  assign sts_o.hls      = hls_q;
  assign sts_o.hls_done = (ch_q == ssd_pkg::HLS_LAST_CH) &&
                          (step_q == ssd_pkg::HLS_LAST_STEP);
  assign sts_o.out_busy = ov_q && !out_ready_i;

  assign out_valid_o     = ov_q;
  assign draw_valid_o    = odv_q;
  assign draw_x_o        = ox_q;
  assign draw_row_o      = orow_q;
  assign run_length_o    = orun_q;
  assign row_mask_o      = omask_q;
  assign color_rgb_o     = ocol_q;
  assign extent_width_o  = oew_q;
  assign extent_height_o = oeh_q;

endmodule

/* sv/sixel_stream_decoder.sv */
// ----------------------------------------------------------------------------
// sixel_stream_decoder
// Sixel byte stream to run writes with palette colors and image extents.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one stream byte per transfer, with
// start_image_i set on the first byte of an image to clear cursor, parser,
// extents, raster size, selected color and palette defined flags.
// Output channel (out_valid_o/out_ready_i): exactly one result per byte; a
// run write when draw_valid_o is high, extents always.
// Configuration: cfg_we_i writes clip width (index 0) or height (index 1).
// Color defines: a byte that closes an RGB color define writes the palette
// before its result; one that closes an HLS define first converts the color
// in the HLS unit (three channels of 4 steps each).
// The sequencer handles one byte at a time: a new byte is taken only after
// the result of the last one is loaded into the output register.
// Reset: clip size returns to MAX_SIDE, all parser state clears; the palette
// store holds unknown data but every entry reads black until defined.
// Stall: a finished result waits in the output register; the next byte is
// taken meanwhile and its processing holds at the output until the
// register frees.
// ----------------------------------------------------------------------------
module sixel_stream_decoder #(
  parameter int unsigned MAX_SIDE      = ssd_pkg::MAX_SIDE_DEF,
  parameter int unsigned PALETTE_DEPTH = ssd_pkg::PAL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        start_image_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        draw_valid_o,
  output logic [17:0] draw_x_o,
  output logic [17:0] draw_row_o,
  output logic [16:0] run_length_o,
  output logic [5:0]  row_mask_o,
  output logic [23:0] color_rgb_o,
  output logic [17:0] extent_width_o,
  output logic [17:0] extent_height_o
);

  ssd_pkg::cmd_t cmd;
  ssd_pkg::sts_t sts;

  ssd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssd_dp #(
    .MAX_SIDE      (MAX_SIDE),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .stream_byte_i   (stream_byte_i),
    .start_image_i   (start_image_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .draw_valid_o    (draw_valid_o),
    .draw_x_o        (draw_x_o),
    .draw_row_o      (draw_row_o),
    .run_length_o    (run_length_o),
    .row_mask_o      (row_mask_o),
    .color_rgb_o     (color_rgb_o),
    .extent_width_o  (extent_width_o),
    .extent_height_o (extent_height_o)
  );

endmodule

/* sv/ssd_checker.sv */
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks of the sixel stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        draw_valid_o,
  input logic [16:0] run_length_o,
  input logic [5:0]  row_mask_o,
  input logic [23:0] color_rgb_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_mask_o))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second byte taken while one is in work");

  a_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !draw_valid_o |-> row_mask_o == '0 && run_length_o == '0 &&
    color_rgb_o == '0)
    else $error("no-draw result carries run data");

  a_real_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && draw_valid_o |-> row_mask_o != '0 && run_length_o != '0)
    else $error("draw result writes nothing");

endmodule

bind sixel_stream_decoder ssd_checker u_ssd_checker (.*);
